>>> hw/rtl/htw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htw_pkg
// Shared types and constants of the hierarchical timing wheel.
// ----------------------------------------------------------------------------
package htw_pkg;

   // request opcodes
   localparam logic [1:0] OP_INSERT   = 2'd0;
   localparam logic [1:0] OP_TICK     = 2'd1;
   localparam logic [1:0] OP_DISPATCH = 2'd2;

   // timer pool
   localparam int MAX_TIMERS = 64;
   localparam int ENT_W      = $clog2(MAX_TIMERS);
   localparam int LINK_W     = 7;                 // entry index plus empty marker
   localparam logic [LINK_W-1:0] EMPTY_MARK = 7'h7F;

   // wheel geometry
   localparam int NEAR_BITS  = 8;
   localparam int LEVEL_BITS = 6;
   localparam int NUM_LEVELS = 4;
   localparam int SLOT_AW    = 9;                 // near/level select plus slot

   // front to back queue
   localparam int QDEPTH = 2;
   localparam int QPTR_W = 1;
   localparam int QCNT_W = 2;

   // classified transaction handed to the back end
   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] id;
      logic [30:0] delay;   // already clamped to non-negative
   } htw_item_type;

endpackage

>>> hw/rtl/htw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htw_front
// Accepts request transactions, clamps the delay, drops unused opcodes and
// queues the rest for the back end.
// ----------------------------------------------------------------------------
module htw_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_op,
   input  logic [63:0]          req_timer_id,
   input  logic signed [31:0]   req_delay,
   output logic                 q_valid,
   input  logic                 q_ready,
   output htw_pkg::htw_item_type q_item
);

   localparam int QCNT_W = htw_pkg::QCNT_W;

   htw_pkg::htw_item_type        q_mem [htw_pkg::QDEPTH];
   logic [htw_pkg::QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [htw_pkg::QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [htw_pkg::QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                         acc, push, pop;
   htw_pkg::htw_item_type        item;

   assign req_ready = (cnt_ff != htw_pkg::QCNT_W'(htw_pkg::QDEPTH));
   assign acc       = req_valid && req_ready;

   // classify: unused opcode is taken and forgotten
   always_comb begin
      item.kind  = req_op;
      item.id    = req_timer_id;
      item.delay = req_delay[31] ? 31'd0 : req_delay[30:0];
   end

   assign push = acc && (req_op == htw_pkg::OP_INSERT || req_op == htw_pkg::OP_TICK ||
                         req_op == htw_pkg::OP_DISPATCH);
   assign pop  = q_valid && q_ready;

   assign q_valid = (cnt_ff != '0);
   assign q_item  = q_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

>>> hw/rtl/htw_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htw_engine
// Back end: owns the tick counter, slot lists and entry pool; runs inserts,
// cascades and dispatches one step at a time and drives the result register.
// ----------------------------------------------------------------------------
module htw_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_ready,
   input  htw_pkg::htw_item_type q_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [63:0]           rsp_expired_id,
   output logic                  rsp_last_expired,
   output logic                  rsp_dropped
);

   localparam int ENT_W   = htw_pkg::ENT_W;
   localparam int LINK_W  = htw_pkg::LINK_W;
   localparam int SLOT_AW = htw_pkg::SLOT_AW;
   localparam int SLOT_DW = LINK_W + ENT_W;     // {head link, tail}
   localparam int NSLOT   = 1 << SLOT_AW;
   localparam int NTIMER  = htw_pkg::MAX_TIMERS;
   localparam int CNT_W   = ENT_W + 1;

   localparam logic [LINK_W-1:0]  EMPTY_MARK_L = htw_pkg::EMPTY_MARK;
   localparam logic [SLOT_DW-1:0] SLOT_EMPTY   = {EMPTY_MARK_L, {ENT_W{1'b0}}};

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_DROP = 4'd1;
   localparam logic [3:0] S_FRD  = 4'd2;
   localparam logic [3:0] S_FWR  = 4'd3;
   localparam logic [3:0] S_CRD  = 4'd4;
   localparam logic [3:0] S_CHD  = 4'd5;
   localparam logic [3:0] S_WRD  = 4'd6;
   localparam logic [3:0] S_WFL  = 4'd7;
   localparam logic [3:0] S_DRD  = 4'd8;
   localparam logic [3:0] S_DHD  = 4'd9;
   localparam logic [3:0] S_ERD  = 4'd10;
   localparam logic [3:0] S_OUT  = 4'd11;
   localparam logic [3:0] S_CLR  = 4'd12;

   // slot a timer with expiry t belongs to, seen from tick ct
   function automatic logic [SLOT_AW-1:0] file_slot(input logic [31:0] t,
                                                    input logic [31:0] ct);
      logic [1:0] lvl;
      logic [5:0] idx;
      if ((t | 32'h0000_00FF) == (ct | 32'h0000_00FF)) begin
         return {1'b0, t[7:0]};
      end
      if ((t | 32'h0000_3FFF) == (ct | 32'h0000_3FFF)) lvl = 2'd0;
      else if ((t | 32'h000F_FFFF) == (ct | 32'h000F_FFFF)) lvl = 2'd1;
      else if ((t | 32'h03FF_FFFF) == (ct | 32'h03FF_FFFF)) lvl = 2'd2;
      else lvl = 2'd3;
      unique case (lvl)
         2'd0: idx = t[13:8];
         2'd1: idx = t[19:14];
         2'd2: idx = t[25:20];
         default: idx = t[31:26];
      endcase
      return {1'b1, lvl, idx};
   endfunction

   // lowest free pool entry
   function automatic logic [ENT_W-1:0] first_free(input logic [NTIMER-1:0] m);
      logic [ENT_W-1:0] r;
      r = '0;
      for (int i = NTIMER - 1; i >= 0; i--) begin
         if (m[i]) r = ENT_W'(i);
      end
      return r;
   endfunction

   // memories
   logic [63:0]              ident_mem  [NTIMER];
   logic [31:0]              expiry_mem [NTIMER];
   logic [LINK_W-1:0]        next_mem   [NTIMER];
   logic [SLOT_DW-1:0]       slot_mem   [NSLOT];    // {head link, tail}

   logic [3:0]               state_ff, state_in;
   logic [31:0]              tick_ff, tick_in;
   logic [NTIMER-1:0]        free_ff, free_in;
   logic [ENT_W-1:0]         cur_e_ff, cur_e_in;
   logic [LINK_W-1:0]        nx_ff, nx_in;
   logic [31:0]              cur_t_ff, cur_t_in;
   logic [SLOT_AW-1:0]       slot_ff, slot_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     walk_ff, walk_in;
   logic [63:0]              drop_id_ff, drop_id_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [63:0]              rsp_id_ff, rsp_id_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic                     rsp_drop_ff, rsp_drop_in;

   // read data registers
   logic [63:0]              ident_q;
   logic [31:0]              expiry_q;
   logic [LINK_W-1:0]        next_q;
   logic [SLOT_DW-1:0]       slot_q;

   // memory port controls
   logic                     slot_rd_en, slot_wr_en;
   logic [SLOT_AW-1:0]       slot_rd_addr;
   logic [SLOT_DW-1:0]       slot_wr_data;
   logic                     ent_rd_en, ent_new;
   logic                     next_wr_en;
   logic [ENT_W-1:0]         next_wr_addr;
   logic [LINK_W-1:0]        next_wr_data;

   logic                     out_free, last_hit, slot_empty;
   logic [31:0]              ct_next;
   logic                     casc;
   logic [SLOT_AW-1:0]       casc_slot;
   logic [ENT_W-1:0]         alloc_e;
   logic [SLOT_AW-1:0]       fslot;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign alloc_e    = first_free(free_ff);
   assign fslot      = file_slot(cur_t_ff, tick_ff);
   assign ct_next    = tick_ff + 32'd1;
   assign last_hit   = next_q[LINK_W-1] || (cnt_ff == CNT_W'(NTIMER - 1));
   assign slot_empty = slot_q[SLOT_DW-1];   // head link holds the empty marker

   // level slot that rolls over on the next tick
   always_comb begin
      casc      = 1'b0;
      casc_slot = '0;
      priority if (ct_next == 32'd0) begin
         casc      = 1'b1;
         casc_slot = {1'b1, 2'd3, 6'd0};
      end else if (ct_next[7:0] != 8'd0) begin
         casc = 1'b0;
      end else if (ct_next[13:8] != 6'd0) begin
         casc      = 1'b1;
         casc_slot = {1'b1, 2'd0, ct_next[13:8]};
      end else if (ct_next[19:14] != 6'd0) begin
         casc      = 1'b1;
         casc_slot = {1'b1, 2'd1, ct_next[19:14]};
      end else if (ct_next[25:20] != 6'd0) begin
         casc      = 1'b1;
         casc_slot = {1'b1, 2'd2, ct_next[25:20]};
      end else begin
         casc      = 1'b1;
         casc_slot = {1'b1, 2'd3, ct_next[31:26]};
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      tick_in      = tick_ff;
      free_in      = free_ff;
      cur_e_in     = cur_e_ff;
      nx_in        = nx_ff;
      cur_t_in     = cur_t_ff;
      slot_in      = slot_ff;
      cnt_in       = cnt_ff;
      walk_in      = walk_ff;
      drop_id_in   = drop_id_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_id_in    = rsp_id_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_drop_in  = rsp_drop_ff;
      q_ready      = 1'b0;
      slot_rd_en   = 1'b0;
      slot_rd_addr = slot_ff;
      slot_wr_en   = 1'b0;
      slot_wr_data = SLOT_EMPTY;
      ent_rd_en    = 1'b0;
      ent_new      = 1'b0;
      next_wr_en   = 1'b0;
      next_wr_addr = cur_e_ff;
      next_wr_data = EMPTY_MARK_L;

      unique case (state_ff)
         S_CLR: begin
            // mark every slot list empty after reset
            slot_wr_en = 1'b1;
            slot_in    = slot_ff + 1'b1;
            if (slot_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            q_ready = 1'b1;
            if (q_valid) begin
               unique case (q_item.kind)
                  htw_pkg::OP_INSERT: begin
                     if (free_ff == '0) begin
                        drop_id_in = q_item.id;
                        state_in   = S_DROP;
                     end else begin
                        ent_new  = 1'b1;
                        cur_e_in = alloc_e;
                        cur_t_in = tick_ff + {1'b0, q_item.delay};
                        free_in  = free_ff & ~(NTIMER'(1) << alloc_e);
                        walk_in  = 1'b0;
                        state_in = S_FRD;
                     end
                  end
                  htw_pkg::OP_TICK: begin
                     tick_in = ct_next;
                     if (casc) begin
                        slot_in  = casc_slot;
                        state_in = S_CRD;
                     end else begin
                        state_in = S_DRD;
                     end
                  end
                  default: state_in = S_DRD;
               endcase
            end
         end
         S_DROP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = drop_id_ff;
               rsp_last_in  = 1'b1;
               rsp_drop_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_FRD: begin
            slot_rd_en   = 1'b1;
            slot_rd_addr = fslot;
            slot_in      = fslot;
            next_wr_en   = 1'b1;
            state_in     = S_FWR;
         end
         S_FWR: begin
            slot_wr_en = 1'b1;
            if (!slot_empty) begin
               slot_wr_data = {slot_q[SLOT_DW-1:ENT_W], cur_e_ff};
               next_wr_en   = 1'b1;
               next_wr_addr = slot_q[ENT_W-1:0];
               next_wr_data = {1'b0, cur_e_ff};
            end else begin
               slot_wr_data = {1'b0, cur_e_ff, cur_e_ff};
            end
            if (!walk_ff) begin
               state_in = S_IDLE;
            end else if (!nx_ff[LINK_W-1] && cnt_ff < CNT_W'(NTIMER)) begin
               cur_e_in = nx_ff[ENT_W-1:0];
               state_in = S_WRD;
            end else begin
               state_in = S_DRD;
            end
         end
         S_CRD: begin
            slot_rd_en = 1'b1;
            state_in   = S_CHD;
         end
         S_CHD: begin
            if (!slot_empty) begin
               slot_wr_en = 1'b1;
               cur_e_in   = slot_q[SLOT_DW-2:ENT_W];
               cnt_in     = '0;
               walk_in    = 1'b1;
               state_in   = S_WRD;
            end else begin
               state_in = S_DRD;
            end
         end
         S_WRD: begin
            ent_rd_en = 1'b1;
            state_in  = S_WFL;
         end
         S_WFL: begin
            nx_in    = next_q;
            cur_t_in = expiry_q;
            cnt_in   = cnt_ff + 1'b1;
            state_in = S_FRD;
         end
         S_DRD: begin
            slot_rd_en   = 1'b1;
            slot_rd_addr = {1'b0, tick_ff[7:0]};
            slot_in      = {1'b0, tick_ff[7:0]};
            cnt_in       = '0;
            state_in     = S_DHD;
         end
         S_DHD: begin
            if (!slot_empty) begin
               slot_wr_en = 1'b1;
               cur_e_in   = slot_q[SLOT_DW-2:ENT_W];
               state_in   = S_ERD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_ERD: begin
            ent_rd_en = 1'b1;
            state_in  = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = ident_q;
               rsp_last_in  = last_hit;
               rsp_drop_in  = 1'b0;
               free_in      = free_ff | (NTIMER'(1) << cur_e_ff);
               cnt_in       = cnt_ff + 1'b1;
               if (last_hit) begin
                  state_in = S_IDLE;
               end else begin
                  cur_e_in = next_q[ENT_W-1:0];
                  state_in = S_ERD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // entry pool memories
   always_ff @(posedge clock) begin
      if (ent_new) begin
         ident_mem[alloc_e]  <= q_item.id;
         expiry_mem[alloc_e] <= tick_ff + {1'b0, q_item.delay};
      end
      if (next_wr_en) begin
         next_mem[next_wr_addr] <= next_wr_data;
      end
      if (ent_rd_en) begin
         ident_q  <= ident_mem[cur_e_ff];
         expiry_q <= expiry_mem[cur_e_ff];
         next_q   <= next_mem[cur_e_ff];
      end
   end

   // slot list memory
   always_ff @(posedge clock) begin
      if (slot_wr_en) begin
         slot_mem[slot_ff] <= slot_wr_data;
      end
      if (slot_rd_en) begin
         slot_q <= slot_mem[slot_rd_addr];
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         slot_ff      <= '0;
         tick_ff      <= '0;
         free_ff      <= '1;
         rsp_valid_ff <= 1'b0;
         walk_ff      <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         tick_ff      <= tick_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
         walk_ff      <= walk_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_e_ff    <= cur_e_in;
      nx_ff       <= nx_in;
      cur_t_ff    <= cur_t_in;
      drop_id_ff  <= drop_id_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_last_ff <= rsp_last_in;
      rsp_drop_ff <= rsp_drop_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_expired_id   = rsp_id_ff;
   assign rsp_last_expired = rsp_last_ff;
   assign rsp_dropped      = rsp_drop_ff;

endmodule

>>> hw/rtl/hierarchical_timing_wheel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hierarchical_timing_wheel
// Timer wheel with a 256-slot near wheel and four 64-slot level wheels.
// ----------------------------------------------------------------------------
// After reset the engine marks every slot list empty in turn; requests
// queue meanwhile and are taken once that pass ends. A request is registered
// in the two-deep queue before the engine takes it. An insert then steps the
// engine through take, slot read and slot write; a dropped insert through
// take and result. A tick or dispatch steps through take, slot read and head
// check; a cascade adds a slot read and a head check, plus entry read, entry
// fetch, slot read and slot write for every entry it re-files, and every
// expired timer adds an entry read and a result. Results leave through
// a one-entry output register, and a result the receiver does not take
// stalls the engine until it does.
// ----------------------------------------------------------------------------
module hierarchical_timing_wheel (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_op,
   input  logic [63:0]        req_timer_id,
   input  logic signed [31:0] req_delay,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [63:0]        rsp_expired_id,
   output logic               rsp_last_expired,
   output logic               rsp_dropped
);

   logic                  q_valid;
   logic                  q_ready;
   htw_pkg::htw_item_type q_item;

   // accept and classify
   htw_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_op       (req_op),
      .req_timer_id (req_timer_id),
      .req_delay    (req_delay),
      .q_valid      (q_valid),
      .q_ready      (q_ready),
      .q_item       (q_item)
   );

   // execute
   htw_engine u_engine (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_ready          (q_ready),
      .q_item           (q_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_expired_id   (rsp_expired_id),
      .rsp_last_expired (rsp_last_expired),
      .rsp_dropped      (rsp_dropped)
   );

endmodule

>>> hw/rtl/htw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htw_checker
// Port-level checks of the timing wheel, bound to the top level.
// ----------------------------------------------------------------------------
module htw_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_expired_id,
   input logic        rsp_last_expired,
   input logic        rsp_dropped
);

   // a stalled result holds its id
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_expired_id))
      else $error("result changed while stalled");

   // a stalled result holds its flags
   a_flag_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_dropped) && $stable(rsp_last_expired))
      else $error("result flags changed while stalled");

   // a rejected insert is always the only result of its transaction
   a_drop_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dropped |-> rsp_last_expired)
      else $error("dropped result without last flag");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind hierarchical_timing_wheel htw_checker u_htw_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_expired_id   (rsp_expired_id),
   .rsp_last_expired (rsp_last_expired),
   .rsp_dropped      (rsp_dropped)
);
